// File: rtl/tlik_pkg.sv
// Shared types, constants and the arctangent table for the two-link IK core.
// No dependencies; imported by every other file of the block.
`default_nettype none

package tlik_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_TABLE_LEN    = 24;

    localparam int COORD_W   = 16;
    localparam int LINK_W    = 15;
    localparam int SHLD_W    = 16;
    localparam int ELBW_W    = 15;

    // law of cosines quotient: 18 bits, anything past 65537 is out of reach
    localparam int QUOT_BITS = 18;
    localparam int REM_W     = 50;
    localparam int NUM_W     = 34;
    localparam int COS_W     = 18;

    // integer square root of a 33-bit radicand, 17 result bits
    localparam int RAD_W     = 33;
    localparam int ROOT_BITS = 17;
    localparam int TRIAL_W   = 35;

    localparam int CORD_W    = 36;
    localparam int ANG_W     = 28;

    localparam logic signed [ANG_W-1:0] ANGLE_PI = 28'sd52707179;
    localparam logic [QUOT_BITS-1:0] COS_ONE   = 18'd65536;
    localparam logic [QUOT_BITS-1:0] COS_LIMIT = 18'd65537;

    localparam logic REG_FIRST_LINK  = 1'b0;
    localparam logic REG_SECOND_LINK = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_BAD_LINK    = 2'd1,
        STATUS_UNREACHABLE = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      elbow;
        logic                      num_neg;
        logic                      bad_link;
    } div_side_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      elbow;
        status_t                   status;
        logic signed [COS_W-1:0]   c;
    } root_side_t;

    // atan(2^-i) in Q.24 radians, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic signed [ANG_W-1:0] r;
        unique case (i)
            0:  r = 28'sd13176795;
            1:  r = 28'sd7778716;
            2:  r = 28'sd4110060;
            3:  r = 28'sd2086331;
            4:  r = 28'sd1047214;
            5:  r = 28'sd524117;
            6:  r = 28'sd262123;
            7:  r = 28'sd131069;
            8:  r = 28'sd65536;
            9:  r = 28'sd32768;
            10: r = 28'sd16384;
            11: r = 28'sd8192;
            12: r = 28'sd4096;
            13: r = 28'sd2048;
            14: r = 28'sd1024;
            15: r = 28'sd512;
            16: r = 28'sd256;
            17: r = 28'sd128;
            18: r = 28'sd64;
            19: r = 28'sd32;
            20: r = 28'sd16;
            21: r = 28'sd8;
            22: r = 28'sd4;
            23: r = 28'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/two_link_inverse_kinematics_core.sv
// Top level of the two-link planar arm inverse kinematics core.
// Depends on tlik_pkg and tlik_cordic (three instances).
//
// Usage:
//   Input words (target_x, target_y, elbow_negative) enter on in_valid/in_stall,
//   results (shoulder_angle, elbow_angle, status) leave on out_valid/out_stall.
//   A word moves when valid is high and stall is low at a rising edge.
//   Link lengths are written on cfg_valid/cfg_ready (cfg_ready is always high),
//   cfg_index 0 is link one, 1 is link two; write only while the core is empty.
// Pipeline: one result per word, through the 18-step quotient, the 17-step
//   square root and the CORDIC chain, each one step per register stage.
// Throughput: one word per cycle while not stalled; the whole pipeline advances together.
// Stall: while a result sits in the output register and out_stall is high, the
//   whole pipeline holds, bubbles included, and in_stall is raised.
// Reset: all stage valid bits clear and both link lengths return to 256.
// Status 1 (zero link) or 2 (unreachable) forces both angles to zero.
`default_nettype none

module two_link_inverse_kinematics_core
    import tlik_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [COORD_W-1:0] target_x,
    input  wire logic signed [COORD_W-1:0] target_y,
    input  wire logic                      elbow_negative,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [SHLD_W-1:0]       shoulder_angle,
    output logic signed [ELBW_W-1:0]       elbow_angle,
    output logic [1:0]                     status,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic                      cfg_index,
    input  wire logic [LINK_W-1:0]         cfg_data
);

    localparam int CL = CORDIC_STAGES + 1;

    logic adv;

    // ---------------- configuration
    logic [LINK_W-1:0] l1_reg;
    logic [LINK_W-1:0] l2_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_reg <= 15'd256;
            l2_reg <= 15'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FIRST_LINK:  l1_reg <= cfg_data;
                REG_SECOND_LINK: l2_reg <= cfg_data;
                default:         l1_reg <= l1_reg;
            endcase
        end
    end

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // ---------------- stage 1: squares and link product
    logic              s1_valid_reg;
    logic [31:0]       s1_x2_reg, s1_y2_reg;
    logic [29:0]       s1_l1sq_reg, s1_l2sq_reg, s1_lp_reg;
    div_side_t         s1_side_reg;

    logic signed [31:0] xs, ys;
    logic [31:0]        s1_x2_next, s1_y2_next;
    logic [29:0]        s1_l1sq_next, s1_l2sq_next, s1_lp_next;
    div_side_t          s1_side_next;

    assign xs           = 32'(target_x);
    assign ys           = 32'(target_y);
    assign s1_x2_next   = 32'(xs * xs);
    assign s1_y2_next   = 32'(ys * ys);
    assign s1_l1sq_next = 30'(l1_reg) * 30'(l1_reg);
    assign s1_l2sq_next = 30'(l2_reg) * 30'(l2_reg);
    assign s1_lp_next   = 30'(l1_reg) * 30'(l2_reg);

    always_comb
    begin
        s1_side_next.x        = target_x;
        s1_side_next.y        = target_y;
        s1_side_next.elbow    = elbow_negative;
        s1_side_next.num_neg  = 1'b0;
        s1_side_next.bad_link = (l1_reg == '0) || (l2_reg == '0);
    end

    // ---------------- stage 2: numerator of the law of cosines
    logic                    s2_valid_reg;
    logic signed [NUM_W-1:0] s2_num_reg;
    logic [29:0]             s2_lp_reg;
    div_side_t               s2_side_reg;

    logic signed [NUM_W-1:0] s2_num_next;

    assign s2_num_next = $signed(NUM_W'(s1_x2_reg)) + $signed(NUM_W'(s1_y2_reg))
                       - $signed(NUM_W'(s1_l1sq_reg)) - $signed(NUM_W'(s1_l2sq_reg));

    // ---------------- stage 3 and divider: q = (|num|*2^16 + den/2) / den
    logic              div_valid_reg [0:QUOT_BITS];
    logic [REM_W-1:0]  div_rem_reg   [0:QUOT_BITS];
    logic [30:0]       div_den_reg   [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] div_q_reg  [0:QUOT_BITS];
    logic              div_hi_reg    [0:QUOT_BITS];
    div_side_t         div_side_reg  [0:QUOT_BITS];

    logic [NUM_W-1:0]  s2_abs;
    logic [REM_W-1:0]  div_rem0_next;
    div_side_t         div_side0_next;

    assign s2_abs        = s2_num_reg[NUM_W-1] ? NUM_W'(-s2_num_reg) : NUM_W'(s2_num_reg);
    assign div_rem0_next = (REM_W'(s2_abs[31:0]) << 16) + REM_W'(s2_lp_reg);

    always_comb
    begin
        div_side0_next         = s2_side_reg;
        div_side0_next.num_neg = s2_num_reg[NUM_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            div_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg     <= in_valid;
            s2_valid_reg     <= s1_valid_reg;
            div_valid_reg[0] <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x2_reg       <= s1_x2_next;
            s1_y2_reg       <= s1_y2_next;
            s1_l1sq_reg     <= s1_l1sq_next;
            s1_l2sq_reg     <= s1_l2sq_next;
            s1_lp_reg       <= s1_lp_next;
            s1_side_reg     <= s1_side_next;
            s2_num_reg      <= s2_num_next;
            s2_lp_reg       <= s1_lp_reg;
            s2_side_reg     <= s1_side_reg;
            div_rem_reg[0]  <= div_rem0_next;
            div_den_reg[0]  <= {s2_lp_reg, 1'b0};
            div_q_reg[0]    <= '0;
            div_hi_reg[0]   <= 1'b0;
            div_side_reg[0] <= div_side0_next;
        end
    end

    for (genvar j = 0; j < QUOT_BITS; j++)
    begin : g_div
        localparam int K = QUOT_BITS - 1 - j;
        logic [REM_W-1:0]     sub;
        logic                 ge;
        logic [REM_W-1:0]     rem_next;
        logic [QUOT_BITS-1:0] q_next;
        logic                 hi_next;

        assign sub      = REM_W'(div_den_reg[j]) << K;
        assign ge       = div_rem_reg[j] >= sub;
        assign rem_next = ge ? div_rem_reg[j] - sub : div_rem_reg[j];

        always_comb
        begin
            q_next    = div_q_reg[j];
            q_next[K] = ge;
        end

        // first step also flags a quotient beyond the top bit
        if (j == 0)
        begin : g_hi
            assign hi_next = div_rem_reg[j] >= (REM_W'(div_den_reg[j]) << QUOT_BITS);
        end
        else
        begin : g_nohi
            assign hi_next = div_hi_reg[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_valid_reg[j+1] <= 1'b0;
            else if (adv)
                div_valid_reg[j+1] <= div_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_rem_reg[j+1]  <= rem_next;
                div_den_reg[j+1]  <= div_den_reg[j];
                div_q_reg[j+1]    <= q_next;
                div_hi_reg[j+1]   <= hi_next;
                div_side_reg[j+1] <= div_side_reg[j];
            end
        end
    end

    // ---------------- C1: clamp cosine, decide status
    logic       c1_valid_reg;
    root_side_t c1_side_reg;

    logic                  unreach;
    logic [QUOT_BITS-1:0]  cmag;
    root_side_t            c1_side_next;
    div_side_t             dq_side;

    assign dq_side = div_side_reg[QUOT_BITS];
    assign unreach = div_hi_reg[QUOT_BITS] || (div_q_reg[QUOT_BITS] > COS_LIMIT);
    assign cmag    = (div_q_reg[QUOT_BITS] > COS_ONE) ? COS_ONE : div_q_reg[QUOT_BITS];

    always_comb
    begin
        c1_side_next.x     = dq_side.x;
        c1_side_next.y     = dq_side.y;
        c1_side_next.elbow = dq_side.elbow;
        c1_side_next.c     = dq_side.num_neg ? -$signed(cmag) : $signed(cmag);
        priority if (dq_side.bad_link)
            c1_side_next.status = STATUS_BAD_LINK;
        else if (unreach)
            c1_side_next.status = STATUS_UNREACHABLE;
        else
            c1_side_next.status = STATUS_OK;
    end

    // ---------------- C2 and square root: s = floor(sqrt(2^32 - c^2))
    logic                 sq_valid_reg [0:ROOT_BITS];
    logic [RAD_W-1:0]     sq_rad_reg   [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] sq_root_reg  [0:ROOT_BITS];
    root_side_t           sq_side_reg  [0:ROOT_BITS];

    logic signed [35:0] cc;
    logic [RAD_W-1:0]   sq_rad0_next;

    assign cc           = 36'(c1_side_reg.c) * 36'(c1_side_reg.c);
    assign sq_rad0_next = {1'b1, 32'd0} - RAD_W'(cc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg    <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            c1_valid_reg    <= div_valid_reg[QUOT_BITS];
            sq_valid_reg[0] <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_side_reg    <= c1_side_next;
            sq_rad_reg[0]  <= sq_rad0_next;
            sq_root_reg[0] <= '0;
            sq_side_reg[0] <= c1_side_reg;
        end
    end

    for (genvar j = 0; j < ROOT_BITS; j++)
    begin : g_sqrt
        localparam int K = ROOT_BITS - 1 - j;
        logic [TRIAL_W-1:0]   trial;
        logic                 ge;
        logic [RAD_W-1:0]     rad_next;
        logic [ROOT_BITS-1:0] root_next;

        // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
        assign trial    = (TRIAL_W'(sq_root_reg[j]) << (K + 1)) + (TRIAL_W'(1) << (2 * K));
        assign ge       = TRIAL_W'(sq_rad_reg[j]) >= trial;
        assign rad_next = ge ? RAD_W'(TRIAL_W'(sq_rad_reg[j]) - trial) : sq_rad_reg[j];

        always_comb
        begin
            root_next    = sq_root_reg[j];
            root_next[K] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[j+1] <= 1'b0;
            else if (adv)
                sq_valid_reg[j+1] <= sq_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rad_reg[j+1]  <= rad_next;
                sq_root_reg[j+1] <= root_next;
                sq_side_reg[j+1] <= sq_side_reg[j];
            end
        end
    end

    // ---------------- M1: signed sine; M2: CORDIC operands
    logic                    m1_valid_reg;
    logic signed [COS_W-1:0] m1_s_reg;
    root_side_t              m1_side_reg;

    logic signed [COS_W-1:0] m1_s_next;
    root_side_t              sq_side;

    assign sq_side   = sq_side_reg[ROOT_BITS];
    assign m1_s_next = sq_side.elbow ? -$signed(COS_W'(sq_root_reg[ROOT_BITS]))
                                     : $signed(COS_W'(sq_root_reg[ROOT_BITS]));

    logic                     m2_valid_reg;
    status_t                  m2_status_reg;
    logic signed [CORD_W-1:0] m2_xa_reg, m2_ya_reg, m2_xb_reg, m2_yb_reg, m2_xc_reg, m2_yc_reg;

    logic signed [33:0]       l2_s, l2_c;
    logic signed [CORD_W-1:0] m2_xc_next;

    assign l2_s       = 34'($signed({1'b0, l2_reg})) * 34'(m1_s_reg);
    assign l2_c       = 34'($signed({1'b0, l2_reg})) * 34'(m1_side_reg.c);
    assign m2_xc_next = (CORD_W'($signed({1'b0, l1_reg})) <<< 16) + CORD_W'(l2_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_valid_reg <= sq_valid_reg[ROOT_BITS];
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_s_reg      <= m1_s_next;
            m1_side_reg   <= sq_side;
            m2_status_reg <= m1_side_reg.status;
            m2_xa_reg     <= CORD_W'(m1_side_reg.c) <<< 8;
            m2_ya_reg     <= CORD_W'(m1_s_reg) <<< 8;
            m2_xb_reg     <= CORD_W'(m1_side_reg.x) <<< 16;
            m2_yb_reg     <= CORD_W'(m1_side_reg.y) <<< 16;
            m2_xc_reg     <= m2_xc_next;
            m2_yc_reg     <= CORD_W'(l2_s);
        end
    end

    // ---------------- three CORDIC units
    logic signed [ANG_W-1:0] za, zb, zc;

    tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_elbow
    (
        .clk   (clk),
        .en    (adv),
        .x_in  (m2_xa_reg),
        .y_in  (m2_ya_reg),
        .z_out (za)
    );

    tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_target
    (
        .clk   (clk),
        .en    (adv),
        .x_in  (m2_xb_reg),
        .y_in  (m2_yb_reg),
        .z_out (zb)
    );

    tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_offset
    (
        .clk   (clk),
        .en    (adv),
        .x_in  (m2_xc_reg),
        .y_in  (m2_yc_reg),
        .z_out (zc)
    );

    // status and valid ride alongside the CORDIC chain
    logic    cd_valid_reg  [0:CL];
    status_t cd_status_reg [0:CL];

    assign cd_valid_reg[0]  = m2_valid_reg;
    assign cd_status_reg[0] = m2_status_reg;

    for (genvar j = 0; j < CL; j++)
    begin : g_delay
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cd_valid_reg[j+1] <= 1'b0;
            else if (adv)
                cd_valid_reg[j+1] <= cd_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                cd_status_reg[j+1] <= cd_status_reg[j];
        end
    end

    // ---------------- output stage: round Q.24 to Q4.12 (shoulder) and Q3.12 (elbow)
    logic                    out_valid_reg;
    logic signed [SHLD_W-1:0] shoulder_reg;
    logic signed [ELBW_W-1:0] elbow_reg;
    status_t                  status_reg;

    logic signed [ANG_W-1:0]  za_rnd;
    logic signed [ANG_W:0]    zd_rnd;
    logic signed [SHLD_W-1:0] shoulder_next;
    logic signed [ELBW_W-1:0] elbow_next;

    assign za_rnd = (za + ANG_W'(2048)) >>> 12;
    assign zd_rnd = ((ANG_W+1)'(zb) - (ANG_W+1)'(zc) + (ANG_W+1)'(2048)) >>> 12;

    always_comb
    begin
        if (cd_status_reg[CL] == STATUS_OK)
        begin
            shoulder_next = zd_rnd[SHLD_W-1:0];
            elbow_next    = za_rnd[ELBW_W-1:0];
        end
        else
        begin
            shoulder_next = '0;
            elbow_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= cd_valid_reg[CL];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            shoulder_reg <= shoulder_next;
            elbow_reg    <= elbow_next;
            status_reg   <= cd_status_reg[CL];
        end
    end

    assign out_valid      = out_valid_reg;
    assign shoulder_angle = shoulder_reg;
    assign elbow_angle    = elbow_reg;
    assign status         = status_reg;

endmodule

`default_nettype wire

// File: rtl/tlik_cordic.sv
// Pipelined CORDIC vectoring unit: atan2(y, x) in Q.24 radians.
// Depends on tlik_pkg (widths, pi, arctangent table).
`default_nettype none

module tlik_cordic
    import tlik_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [CORD_W-1:0] x_in,
    input  wire logic signed [CORD_W-1:0] y_in,
    output logic signed [ANG_W-1:0]      z_out
);

    logic signed [CORD_W-1:0] x_reg    [0:STAGES];
    logic signed [CORD_W-1:0] y_reg    [0:STAGES];
    logic signed [ANG_W-1:0]  z_reg    [0:STAGES];
    logic                     zero_reg [0:STAGES];

    logic signed [CORD_W-1:0] x0_next;
    logic signed [CORD_W-1:0] y0_next;
    logic signed [ANG_W-1:0]  z0_next;
    logic                     zero0_next;

    // left half plane: rotate by pi first, sign taken from y
    always_comb
    begin
        zero0_next = (x_in == '0) && (y_in == '0);
        if (x_in < 0)
        begin
            x0_next = -x_in;
            y0_next = -y_in;
            z0_next = (y_in >= 0) ? ANGLE_PI : -ANGLE_PI;
        end
        else
        begin
            x0_next = x_in;
            y0_next = y_in;
            z0_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            zero_reg[0] <= zero0_next;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        logic signed [CORD_W-1:0] dx;
        logic signed [CORD_W-1:0] dy;
        logic signed [CORD_W-1:0] x_next;
        logic signed [CORD_W-1:0] y_next;
        logic signed [ANG_W-1:0]  z_next;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_comb
        begin
            if (!y_reg[i][CORD_W-1])
            begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + atan_entry(i);
            end
            else
            begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - atan_entry(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // atan2(0, 0) is defined as zero
    assign z_out = zero_reg[STAGES] ? '0 : z_reg[STAGES];

endmodule

`default_nettype wire

// File: rtl/tlik_checker.sv
// Port-level checks for the two-link IK core, bound onto the top level.
// Depends on tlik_pkg and two_link_inverse_kinematics_core.
`default_nettype none

module tlik_checker
    import tlik_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic signed [COORD_W-1:0] target_x,
    input wire logic signed [COORD_W-1:0] target_y,
    input wire logic                      elbow_negative,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic signed [SHLD_W-1:0]  shoulder_angle,
    input wire logic signed [ELBW_W-1:0]  elbow_angle,
    input wire logic [1:0]                status,
    input wire logic                      cfg_valid,
    input wire logic                      cfg_ready,
    input wire logic                      cfg_index,
    input wire logic [LINK_W-1:0]         cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(shoulder_angle)
            && $stable(elbow_angle) && $stable(status))
        else $error("result word changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |-> (shoulder_angle == '0) && (elbow_angle == '0))
        else $error("error status with nonzero angles");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |-> !in_stall)
        else $error("input stalled while result is taken");

endmodule

bind two_link_inverse_kinematics_core tlik_checker u_tlik_checker (.*);

`default_nettype wire
